// ===== rtl/u8vc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8vc_pkg
// Shared types and constants for the UTF-8 stream validate and count unit.
// ----------------------------------------------------------------------------
package u8vc_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned SKIP_W  = 2;
  localparam int unsigned COUNT_W = 17;

  // Code point count saturates at the longest supported text
  localparam logic [COUNT_W-1:0] COUNT_CAP = 17'd65536;

  // One byte of text as held in the input stage
  typedef struct packed {
    logic [BYTE_W-1:0] text_byte;
    logic              final_byte;
  } u8vc_item_t;

  // One result as held in the output stage
  typedef struct packed {
    logic               is_valid;
    logic [COUNT_W-1:0] codepoint_total;
  } u8vc_result_t;

endpackage : u8vc_pkg

// ===== rtl/u8vc_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8vc_in_reg
// Input register stage: captures one byte per cycle unless stalled and hands
// it to the tracker when the tracker can take it.
// ----------------------------------------------------------------------------
module u8vc_in_reg
  import u8vc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] in_text_byte,
  input  logic              in_final_byte,
  input  logic              go,
  output logic              stage_vld,
  output u8vc_item_t        stage_item
);

  logic       vld_r;
  logic       vld_nxt;
  u8vc_item_t item_r;
  logic       take;

  // Hold the byte only while it waits for a free output slot
  assign in_stall = vld_r && !go;
  assign take     = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (take) begin
      vld_nxt = 1'b1;
    end else if (go) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      item_r.text_byte  <= in_text_byte;
      item_r.final_byte <= in_final_byte;
    end
  end

  assign stage_vld  = vld_r;
  assign stage_item = item_r;

endmodule : u8vc_in_reg

// ===== rtl/u8vc_track.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8vc_track
// Per-text state and the one-byte step: lead decode, continuation check,
// saturating code point count.
// ----------------------------------------------------------------------------
module u8vc_track
  import u8vc_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         go,
  input  u8vc_item_t   item,
  output u8vc_result_t result
);

  logic [SKIP_W-1:0]  skip_r;
  logic [SKIP_W-1:0]  skip_nxt;
  logic               err_r;
  logic               err_nxt;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;

  always_comb begin
    skip_nxt  = skip_r;
    err_nxt   = err_r;
    count_nxt = count_r;
    if (skip_r != '0) begin
      if (item.text_byte[7:6] != 2'b10) begin
        err_nxt = 1'b1;
      end
      skip_nxt = skip_r - 1'b1;
    end else begin
      if (count_r < COUNT_CAP) begin
        count_nxt = count_r + 1'b1;
      end
      case (item.text_byte) inside
        [8'h00:8'h7F]: skip_nxt = 2'd0;
        [8'hC0:8'hDF]: skip_nxt = 2'd1;
        [8'hE0:8'hEF]: skip_nxt = 2'd2;
        [8'hF0:8'hF7]: skip_nxt = 2'd3;
        default: begin
          // stray continuation or impossible lead
          skip_nxt = 2'd0;
          err_nxt  = 1'b1;
        end
      endcase
    end
  end

  assign result.is_valid        = !err_nxt && (skip_nxt == '0);
  assign result.codepoint_total = count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r  <= '0;
      err_r   <= 1'b0;
      count_r <= '0;
    end else if (go) begin
      if (item.final_byte) begin
        // clear for the next text
        skip_r  <= '0;
        err_r   <= 1'b0;
        count_r <= '0;
      end else begin
        skip_r  <= skip_nxt;
        err_r   <= err_nxt;
        count_r <= count_nxt;
      end
    end
  end

endmodule : u8vc_track

// ===== rtl/u8vc_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8vc_out_reg
// Output register: holds one finished result until the sink takes it.
// ----------------------------------------------------------------------------
module u8vc_out_reg
  import u8vc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  u8vc_result_t       result,
  output logic               free,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_is_valid,
  output logic [COUNT_W-1:0] out_codepoint_total
);

  logic         vld_r;
  logic         vld_nxt;
  u8vc_result_t res_r;

  assign free = !vld_r || !out_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = 1'b1;
    end else if (!out_stall) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= result;
    end
  end

  assign out_valid           = vld_r;
  assign out_is_valid        = res_r.is_valid;
  assign out_codepoint_total = res_r.codepoint_total;

endmodule : u8vc_out_reg

// ===== rtl/utf8_stream_validate_count_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utf8_stream_validate_count_unit
// Structural UTF-8 check and code point count over a byte stream.
// ----------------------------------------------------------------------------
// Takes one byte per clock while in_stall is low; the byte flagged final
// closes the text and yields one transaction on the out channel (is_valid,
// codepoint_total), the other bytes yield none. A result passes through the
// input register and then the output register. The rate is one byte per
// cycle, set by the state update in the tracker; a stalled result holds the
// input only when the byte waiting in the input register is itself a final
// byte. Overlong forms and surrogates pass; the count saturates at 65536. No
// clearing after reset.
module utf8_stream_validate_count_unit
  import u8vc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [BYTE_W-1:0]  in_text_byte,
  input  logic               in_final_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_is_valid,
  output logic [COUNT_W-1:0] out_codepoint_total
);

  logic         stage_vld;
  u8vc_item_t   stage_item;
  u8vc_result_t result;
  logic         out_free;
  logic         go;
  logic         load;

  // Advance the byte unless it is final and the output slot is taken
  assign go   = stage_vld && (!stage_item.final_byte || out_free);
  assign load = go && stage_item.final_byte;

  u8vc_in_reg u_in_reg (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_text_byte  (in_text_byte),
    .in_final_byte (in_final_byte),
    .go            (go),
    .stage_vld     (stage_vld),
    .stage_item    (stage_item)
  );

  u8vc_track u_track (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (go),
    .item   (stage_item),
    .result (result)
  );

  u8vc_out_reg u_out_reg (
    .clk                 (clk),
    .rst_n               (rst_n),
    .load                (load),
    .result              (result),
    .free                (out_free),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_is_valid        (out_is_valid),
    .out_codepoint_total (out_codepoint_total)
  );

endmodule : utf8_stream_validate_count_unit

// ===== rtl/u8vc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8vc_checker
// Port-level checks for the UTF-8 stream validate and count unit.
// ----------------------------------------------------------------------------
module u8vc_checker
  import u8vc_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [BYTE_W-1:0]  in_text_byte,
  input logic               in_final_byte,
  input logic               out_valid,
  input logic               out_stall,
  input logic               out_is_valid,
  input logic [COUNT_W-1:0] out_codepoint_total
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_is_valid)
      && $stable(out_codepoint_total))
    else $error("stalled result changed");

  // Every text counts at least its first byte, never past the cap
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_codepoint_total != '0) && (out_codepoint_total <= COUNT_CAP))
    else $error("code point total out of range");

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

  // A result shows up in an empty output only after an accepted final byte
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_final_byte, 2))
    else $error("result without a final byte");

  // A stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_text_byte)
      && $stable(in_final_byte))
    else $error("stalled input changed");

endmodule : u8vc_checker

bind utf8_stream_validate_count_unit u8vc_checker u_u8vc_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_stall            (in_stall),
  .in_text_byte        (in_text_byte),
  .in_final_byte       (in_final_byte),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_is_valid        (out_is_valid),
  .out_codepoint_total (out_codepoint_total)
);
